// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the traversal unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, cond, cons) \
  `ASSERT_CLK(lbl, (cond) |-> (cons))

`endif

// ===== rtl/gbt_pkg.sv =====
// Package with the sizes, codes and types of the graph traversal unit.
package gbt_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 512;

  // Index widths of the vertex and edge stores.
  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned EW    = $clog2(MAX_EDGES);
  // Link width: an edge number or the null link.
  localparam int unsigned LW    = $clog2(MAX_EDGES + 1);
  // Width of counters that reach the vertex capacity itself.
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  // Field widths of the interface.
  localparam int unsigned VTX_W    = 6;
  localparam int unsigned VC_W     = 7;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 1'b1;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_TRAVERSE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One result handed from the walker to the output register.
  typedef struct packed {
    logic              valid;
    logic [VTX_W-1:0]  vtx;
    status_e           st;
    logic              last;
  } res_t;

endpackage

// ===== rtl/gbt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
module gbt_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write first port, registered read on the second.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gbt_walk.sv =====
// Command sequencer and graph memories: list appends, clear and both walks.
module gbt_walk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [gbt_pkg::VC_W-1:0]   vc_eff_i,
  input  logic                       mode_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [gbt_pkg::VTX_W-1:0]  vertex_i,
  input  logic [gbt_pkg::VTX_W-1:0]  nbr_i,
  input  logic                       out_free_i,
  output gbt_pkg::res_t              res_o
);
  import gbt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_APP   = 10'b0000000010,
    S_LINK  = 10'b0000000100,
    S_DONE  = 10'b0000001000,
    S_QRD   = 10'b0000010000,
    S_QHD   = 10'b0000100000,
    S_HEAD  = 10'b0001000000,
    S_BEDGE = 10'b0010000000,
    S_DTOP  = 10'b0100000000,
    S_DPOP  = 10'b1000000000
  } state_e;

  state_e                  state_q, state_d;
  logic [MAX_VERTICES-1:0] hvalid_q, hvalid_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [LW-1:0]           edges_q, edges_d;
  logic [CNT_W-1:0]        front_q, front_d;
  logic [CNT_W-1:0]        rear_q, rear_d;
  logic [CNT_W-1:0]        sp_q, sp_d;
  logic [LW-1:0]           cur_e_q, cur_e_d;
  logic [VTX_W-1:0]        v_q, v_d;
  logic [VTX_W-1:0]        nb_q, nb_d;
  logic [VTX_W-1:0]        u_q, u_d;
  logic [EW-1:0]           tail_q, tail_d;
  logic [VTX_W-1:0]        rv_q, rv_d;
  status_e                 rst_q, rst_d;

  // Memory ports.
  logic              vr_we;
  logic [VW-1:0]     vr_waddr, vr_raddr;
  logic [2*EW-1:0]   vr_wdata, vr_rdata;
  logic              tg_we;
  logic [VTX_W-1:0]  tg_rdata;
  logic              lk_we;
  logic [EW-1:0]     lk_waddr;
  logic [LW-1:0]     lk_wdata, lk_rdata;
  logic              sc_we;
  logic [VW-1:0]     sc_waddr, sc_raddr;
  logic [LW-1:0]     sc_wdata, sc_rdata;

  logic [EW-1:0]     head_rd, tail_rd, new_e;
  logic              t_ok;
  logic [CNT_W-1:0]  sp_m1, sp_m2;
  logic              v_bad, nb_bad;
  op_e               op;

  assign head_rd = vr_rdata[2*EW-1:EW];
  assign tail_rd = vr_rdata[EW-1:0];
  assign new_e   = edges_q[EW-1:0];
  assign sp_m1   = sp_q - CNT_W'(1);
  assign sp_m2   = sp_q - CNT_W'(2);
  assign v_bad   = VC_W'(vertex_i) >= vc_eff_i;
  assign nb_bad  = VC_W'(nbr_i) >= vc_eff_i;
  assign op      = op_e'(op_i);
  // A target is taken when it is in range and not yet visited.
  assign t_ok    = (VC_W'(tg_rdata) < vc_eff_i) && !visited_q[tg_rdata[VW-1:0]];

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    hvalid_d  = hvalid_q;
    visited_d = visited_q;
    edges_d   = edges_q;
    front_d   = front_q;
    rear_d    = rear_q;
    sp_d      = sp_q;
    cur_e_d   = cur_e_q;
    v_d       = v_q;
    nb_d      = nb_q;
    u_d       = u_q;
    tail_d    = tail_q;
    rv_d      = rv_q;
    rst_d     = rst_q;
    vr_we     = 1'b0;
    vr_waddr  = v_q[VW-1:0];
    vr_wdata  = {(hvalid_q[v_q[VW-1:0]] ? head_rd : new_e), new_e};
    vr_raddr  = v_q[VW-1:0];
    tg_we     = 1'b0;
    lk_we     = 1'b0;
    lk_waddr  = new_e;
    lk_wdata  = NULL_LINK;
    sc_we     = 1'b0;
    sc_waddr  = rear_q[VW-1:0];
    sc_wdata  = LW'(tg_rdata);
    sc_raddr  = front_q[VW-1:0];
    res_o     = '{valid: 1'b0, vtx: rv_q, st: rst_q, last: 1'b0};

    case (state_q)
      S_IDLE: begin
        vr_raddr = vertex_i[VW-1:0];
        if (in_valid_i) begin
          case (op)
            OP_APPEND: begin
              v_d  = vertex_i;
              nb_d = nbr_i;
              rv_d = '0;
              if (v_bad || nb_bad) begin
                rst_d   = ST_RANGE;
                state_d = S_DONE;
              end else if (edges_q == LW'(MAX_EDGES)) begin
                rst_d   = ST_FULL;
                state_d = S_DONE;
              end else begin
                rst_d   = ST_OK;
                state_d = S_APP;
              end
            end
            OP_CLEAR: begin
              hvalid_d = '0;
              edges_d  = '0;
              rv_d     = '0;
              rst_d    = ST_OK;
              state_d  = S_DONE;
            end
            OP_TRAVERSE: begin
              if (v_bad) begin
                rv_d    = '0;
                rst_d   = ST_RANGE;
                state_d = S_DONE;
              end else begin
                visited_d = '0;
                visited_d[vertex_i[VW-1:0]] = 1'b1;
                rv_d  = vertex_i;
                rst_d = ST_OK;
                u_d   = vertex_i;
                if (mode_i) begin
                  sp_d    = CNT_W'(1);
                  state_d = S_HEAD;
                end else begin
                  sc_we    = 1'b1;
                  sc_waddr = '0;
                  sc_wdata = LW'(vertex_i);
                  front_d  = '0;
                  rear_d   = CNT_W'(1);
                  state_d  = S_QRD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // New edge record and list update of the source vertex.
      S_APP: begin
        tg_we = 1'b1;
        lk_we = 1'b1;
        vr_we = 1'b1;
        hvalid_d[v_q[VW-1:0]] = 1'b1;
        if (hvalid_q[v_q[VW-1:0]]) begin
          tail_d  = tail_rd;
          state_d = S_LINK;
        end else begin
          edges_d = edges_q + LW'(1);
          state_d = S_DONE;
        end
      end

      // Old tail points at the new edge.
      S_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = tail_q;
        lk_wdata = edges_q;
        edges_d  = edges_q + LW'(1);
        state_d  = S_DONE;
      end

      // Held-back last result goes out with the final flag.
      S_DONE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.last  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // Breadth-first: take the next vertex from the queue.
      S_QRD: begin
        if (front_q < rear_q) begin
          front_d = front_q + CNT_W'(1);
          state_d = S_QHD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_QHD: begin
        u_d      = sc_rdata[VTX_W-1:0];
        vr_raddr = sc_rdata[VW-1:0];
        state_d  = S_HEAD;
      end

      // List head of the current vertex starts the edge scan.
      S_HEAD: begin
        cur_e_d = hvalid_q[u_q[VW-1:0]] ? LW'(head_rd) : NULL_LINK;
        state_d = mode_i ? S_DTOP : S_BEDGE;
      end

      // Breadth-first edge scan, one edge per cycle unless a result waits for the output register.
      S_BEDGE: begin
        if (cur_e_q == NULL_LINK) begin
          state_d = S_QRD;
        end else if (t_ok && (rear_q < CNT_W'(MAX_VERTICES))) begin
          if (out_free_i) begin
            res_o.valid = 1'b1;
            rv_d        = tg_rdata;
            visited_d[tg_rdata[VW-1:0]] = 1'b1;
            sc_we       = 1'b1;
            rear_d      = rear_q + CNT_W'(1);
            cur_e_d     = lk_rdata;
          end
        end else begin
          cur_e_d = lk_rdata;
        end
      end

      // Depth-first step on the top of the stack.
      S_DTOP: begin
        vr_raddr = tg_rdata[VW-1:0];
        sc_raddr = sp_m2[VW-1:0];
        if (cur_e_q == NULL_LINK) begin
          if (sp_q == CNT_W'(1)) begin
            state_d = S_DONE;
          end else begin
            sp_d    = sp_m1;
            state_d = S_DPOP;
          end
        end else if (t_ok && (sp_q < CNT_W'(MAX_VERTICES))) begin
          if (out_free_i) begin
            res_o.valid = 1'b1;
            rv_d        = tg_rdata;
            visited_d[tg_rdata[VW-1:0]] = 1'b1;
            sc_we       = 1'b1;
            sc_waddr    = sp_m1[VW-1:0];
            sc_wdata    = lk_rdata;
            sp_d        = sp_q + CNT_W'(1);
            u_d         = tg_rdata;
            state_d     = S_HEAD;
          end
        end else begin
          cur_e_d = lk_rdata;
        end
      end

      // Resume the parent's saved edge.
      S_DPOP: begin
        cur_e_d = sc_rdata;
        state_d = S_DTOP;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hvalid_q  <= '0;
      visited_q <= '0;
      edges_q   <= '0;
      front_q   <= '0;
      rear_q    <= '0;
      sp_q      <= '0;
      cur_e_q   <= NULL_LINK;
    end else begin
      state_q   <= state_d;
      hvalid_q  <= hvalid_d;
      visited_q <= visited_d;
      edges_q   <= edges_d;
      front_q   <= front_d;
      rear_q    <= rear_d;
      sp_q      <= sp_d;
      cur_e_q   <= cur_e_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    nb_q   <= nb_d;
    u_q    <= u_d;
    tail_q <= tail_d;
    rv_q   <= rv_d;
    rst_q  <= rst_d;
  end

  // Per-vertex list head and tail.
  gbt_ram #(.W(2 * EW), .D(MAX_VERTICES)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vr_we),
    .waddr_i (vr_waddr),
    .wdata_i (vr_wdata),
    .raddr_i (vr_raddr),
    .rdata_o (vr_rdata)
  );

  // Edge targets.
  gbt_ram #(.W(VTX_W), .D(MAX_EDGES)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tg_we),
    .waddr_i (new_e),
    .wdata_i (nb_q),
    .raddr_i (cur_e_d[EW-1:0]),
    .rdata_o (tg_rdata)
  );

  // Edge links.
  gbt_ram #(.W(LW), .D(MAX_EDGES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .raddr_i (cur_e_d[EW-1:0]),
    .rdata_o (lk_rdata)
  );

  // Visit queue or saved-edge stack, one walk at a time.
  gbt_ram #(.W(LW), .D(MAX_VERTICES)) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (sc_wdata),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

endmodule

// ===== rtl/graph_bfs_dfs_traversal_unit.sv =====
// Top level of the graph traversal unit: configuration, output register, checks.
//
// Input stream: tuser carries the opcode, tdata the vertex and neighbour.
// Append adds an edge to the tail of a vertex's list, clear empties all
// lists, traverse emits the vertices reached from the start vertex in
// breadth-first or depth-first order (mode register). Every command
// answers with one or more results on the output stream; tlast marks the
// last result of a command. Opcode 3 is dropped without a result.
// The list and edge memories in the sequencer have a registered read.
// One command is worked on at a time; a new one is taken once the last
// result is in the output register. Reset empties all lists and sets 64
// vertices, breadth-first. A stalled receiver holds the output register
// and pauses the walk.
`include "assert_macros.svh"

module graph_bfs_dfs_traversal_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gbt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbt_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [5:0] vertex, [11:6] neighbour, [15:12] zero
  input  logic [15:0]                    s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [5:0] visit_vertex, [7:6] status
  output logic [7:0]                     m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import gbt_pkg::*;

  logic [VC_W-1:0]  vc_q, vc_d, vc_eff;
  logic             mode_q, mode_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_data_q;
  logic             out_last_q;
  logic             out_free;
  res_t             walk_res;

  // Configuration registers.
  always_comb begin
    vc_d   = vc_q;
    mode_d = mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VERTEX_COUNT: vc_d   = cfg_wdata_i[VC_W-1:0];
        CFG_MODE:         mode_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign vc_eff = (vc_q > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vc_q;

  // Output register frees when its transaction completes.
  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign out_valid_d = walk_res.valid ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= VC_W'(64);
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vc_q        <= vc_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_res.valid) begin
      out_data_q <= {walk_res.st, walk_res.vtx};
      out_last_q <= walk_res.last;
    end
  end

  gbt_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vc_eff_i   (vc_eff),
    .mode_i     (mode_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (s_axis_tuser_i),
    .vertex_i   (s_axis_tdata_i[VTX_W-1:0]),
    .nbr_i      (s_axis_tdata_i[2*VTX_W-1:VTX_W]),
    .out_free_i (out_free),
    .res_o      (walk_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // A result is only handed over when the output register can take it.
  `ASSERT_IMPL(a_push_free, walk_res.valid, out_free)
  // No result is produced while a new command may be taken.
  `ASSERT_IMPL(a_idle_quiet, s_axis_tready_o, !walk_res.valid)
  // A held-back final result never leaves the walker twice in a row.
  `ASSERT_CLK(a_last_once, (walk_res.valid && walk_res.last) |=> !walk_res.valid)

endmodule
